FILE: design/srt_pkg.sv
`timescale 1ns / 1ps
package srt_pkg;
  localparam int CapacityDefault = 64;
  localparam int MaxResults = 64;
  localparam int RecW = 64 + 64 + 8 + 48;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LIST   = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_REQ,
    S_SCAN_CHK,
    S_SHIFT_REQ,
    S_SHIFT_WR,
    S_PUT,
    S_EMIT_REQ,
    S_EMIT_WAIT,
    S_OUT,
    S_FAIL,
    S_DUP
  } state_t;

  typedef struct packed {
    logic       load_cmd;
    logic       ptr_zero;
    logic       ptr_inc;
    logic       ptr_to_count;
    logic       ptr_dec;
    logic       rd_ptr;
    logic       rd_ptr_m1;
    logic       wr_shift;
    logic       wr_new;
    logic       count_inc;
    logic       mark_pos;
    logic       set_fail;
    status_t    fail_code;
    logic       load_out;
    logic       out_last;
  } srt_cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic       ptr_end;
    logic       ptr_is_pos;
    logic       key_eq;
    logic       key_lt;
    logic       full;
    logic       empty;
    logic       list_last;
    logic       out_busy;
  } srt_stat_t;

  // rounded division by three of an 18-bit total via reciprocal multiply;
  // ceil(2^20/3) keeps the error below one third for totals this small
  function automatic logic [15:0] mean3(input logic [17:0] tot);
    logic [18:0] t1;
    logic [37:0] prod;
    t1 = {1'b0, tot} + 19'd1;
    prod = {19'd0, t1} * 38'd349526;
    return prod[35:20];
  endfunction
endpackage

FILE: design/sorted_record_table.sv
`timescale 1ns / 1ps
// sorted_record_table: records kept in ascending key order in one RAM.
// Slave channel s_axis_*: one command per transfer (insert, list, find).
// Master channel m_axis_*: result records; tlast marks the final result
// of a command. Failed insert/find gives one record with status 1 or 2.
// Work: a command scans the stored entries through the single RAM read
// port, one read and one key check per entry; insert then shifts the tail
// up, a read and a write per moved entry, before writing the new record.
// List emits the records one at a time, each held while the output stalls.
// One item is worked on at a time; tready is high only when idle.
// Reset clears the entry count and the controller; RAM contents are
// not cleared. When m_axis_tready is low the result register holds and the
// controller waits before loading the next result.
module sorted_record_table import srt_pkg::*; #(
  parameter int Capacity = CapacityDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[1:0], key[65:2], label[129:66], gender_code[137:130],
  // score_first[153:138], score_second[169:154], score_third[185:170]
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], out_key[65:2], out_label[129:66], out_gender[137:130],
  // out_first[153:138], out_second[169:154], out_third[185:170],
  // out_total[203:186], out_mean[219:204]
  output logic [223:0] m_axis_tdata,
  output logic         m_axis_tlast
);
  srt_cmd_t  cmd;
  srt_stat_t st;

  srt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(s_axis_tvalid & s_axis_tready),
    .in_ready(s_axis_tready), .st(st), .cmd(cmd)
  );

  srt_dp #(.Capacity(Capacity)) u_dp (
    .clk(clk), .rst(rst), .in_data(s_axis_tdata), .cmd(cmd), .st(st),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
    .out_last(m_axis_tlast)
  );
endmodule

FILE: design/srt_ram.sv
`timescale 1ns / 1ps
module srt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: design/srt_ctrl.sv
`timescale 1ns / 1ps
module srt_ctrl import srt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  output logic      in_ready,
  input  srt_stat_t st,
  output srt_cmd_t  cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.fail_code = ST_OK;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load_cmd = 1'b1;
          cmd.ptr_zero = 1'b1;
          state_next = S_SCAN_REQ;
        end
      end
      S_SCAN_REQ: begin
        if (st.cmd == CMD_NONE) state_next = S_IDLE;
        else if (st.cmd == CMD_LIST) begin
          state_next = st.empty ? S_IDLE : S_EMIT_REQ;
        end else if (st.ptr_end) begin
          if (st.cmd == CMD_FIND) state_next = S_FAIL;
          else if (st.full) state_next = S_FAIL;
          else begin
            cmd.ptr_to_count = 1'b1;
            state_next = S_SHIFT_REQ;
          end
        end else begin
          cmd.rd_ptr = 1'b1;
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (st.key_eq) begin
          if (st.cmd == CMD_FIND) state_next = S_EMIT_REQ;
          else state_next = S_DUP;
        end else begin
          if (!st.key_lt) cmd.mark_pos = 1'b1;
          cmd.ptr_inc = 1'b1;
          state_next = S_SCAN_REQ;
        end
      end
      S_SHIFT_REQ: begin
        if (st.ptr_is_pos) state_next = S_PUT;
        else begin
          cmd.rd_ptr_m1 = 1'b1;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.ptr_dec = 1'b1;
        state_next = S_SHIFT_REQ;
      end
      S_PUT: begin
        cmd.wr_new = 1'b1;
        cmd.count_inc = 1'b1;
        state_next = S_EMIT_REQ;
      end
      S_EMIT_REQ: begin
        cmd.rd_ptr = 1'b1;
        state_next = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: state_next = S_OUT;
      S_OUT: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          cmd.out_last = (st.cmd != CMD_LIST) || st.list_last;
          if (st.cmd == CMD_LIST && !st.list_last) begin
            cmd.ptr_inc = 1'b1;
            state_next = S_EMIT_REQ;
          end else state_next = S_IDLE;
        end
      end
      // find miss, or insert into a full table
      S_FAIL: begin
        if (!st.out_busy) begin
          cmd.set_fail = 1'b1;
          cmd.fail_code = (st.cmd == CMD_INSERT) ? ST_FULL : ST_MISS;
          state_next = S_IDLE;
        end
      end
      // insert of a key already stored
      S_DUP: begin
        if (!st.out_busy) begin
          cmd.set_fail = 1'b1;
          cmd.fail_code = ST_MISS;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: design/srt_dp.sv
`timescale 1ns / 1ps
module srt_dp import srt_pkg::*; #(
  parameter int Capacity = CapacityDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [191:0] in_data,
  input  srt_cmd_t     cmd,
  output srt_stat_t    st,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [223:0] out_data,
  output logic         out_last
);
  localparam int AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CW = $clog2(Capacity + 1);

  cmd_t          cur_cmd;
  logic [63:0]   cur_key;
  logic [119:0]  cur_rest;
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic [CW-1:0] pos;
  logic          pos_set;
  logic [RecW-1:0] rd_rec;
  logic [RecW-1:0] wdata;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [CW-1:0] ptr_m1;
  logic [CW-1:0] list_n;

  assign ptr_m1 = ptr - CW'(1);
  assign raddr = cmd.rd_ptr_m1 ? ptr_m1[AW-1:0] : ptr[AW-1:0];
  assign we = cmd.wr_shift | cmd.wr_new;
  assign waddr = cmd.wr_new ? pos[AW-1:0] : ptr[AW-1:0];
  assign wdata = cmd.wr_new ? {cur_rest, cur_key} : rd_rec;

  srt_ram #(.Width(RecW), .Depth(Capacity)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rd_rec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cur_cmd <= CMD_NONE;
    end else begin
      if (cmd.load_cmd) cur_cmd <= cmd_t'(in_data[1:0]);
      if (cmd.count_inc) count <= count + CW'(1);
    end
    if (cmd.load_cmd) begin
      cur_key <= in_data[65:2];
      cur_rest <= in_data[185:66];
      pos_set <= 1'b0;
    end
    if (cmd.ptr_zero) ptr <= '0;
    else if (cmd.ptr_to_count) ptr <= count;
    else if (cmd.ptr_inc) ptr <= ptr + CW'(1);
    else if (cmd.ptr_dec) ptr <= ptr_m1;
    if (cmd.ptr_to_count && !pos_set) pos <= count;
    if (cmd.mark_pos && !pos_set) begin
      pos <= ptr;
      pos_set <= 1'b1;
    end
  end

  // output register
  logic [63:0] ok, ol;
  logic [7:0] og;
  logic [47:0] osc;
  status_t ost;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out || cmd.set_fail) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (cmd.load_out) begin
      ost <= ST_OK;
      ok <= rd_rec[63:0];
      ol <= rd_rec[127:64];
      og <= rd_rec[135:128];
      osc <= rd_rec[183:136];
      out_last <= cmd.out_last;
    end else if (cmd.set_fail) begin
      ost <= cmd.fail_code;
      ok <= '0; ol <= '0; og <= '0; osc <= '0;
      out_last <= 1'b1;
    end
  end

  logic [17:0] otot;
  assign otot = 18'(osc[15:0]) + 18'(osc[31:16]) + 18'(osc[47:32]);
  assign out_data = {4'd0, mean3(otot), otot, osc, og, ol, ok, ost};

  assign list_n = (32'(count) > MaxResults) ? CW'(MaxResults) : count;
  assign st.cmd = cur_cmd;
  assign st.ptr_end = (ptr == count);
  assign st.ptr_is_pos = (ptr == pos);
  assign st.key_eq = (rd_rec[63:0] == cur_key);
  assign st.key_lt = rd_rec[63:0] < cur_key;
  assign st.full = (count == CW'(Capacity));
  assign st.empty = (count == '0);
  assign st.list_last = (ptr + CW'(1) == list_n);
  assign st.out_busy = out_valid & ~out_ready;
endmodule

FILE: design/srt_check.sv
`timescale 1ns / 1ps
module srt_check import srt_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [223:0] m_axis_tdata,
  input logic         m_axis_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tlast)
    else $error("failed result not last");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[223:2] == '0)
    else $error("failed result not zero");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted while busy");
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("valid after reset");
endmodule

bind sorted_record_table srt_check u_check (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import srt_pkg::*;

  localparam int Depth = 64;
  localparam int IdleLimit = 20000;
  localparam int RandomItems = 440;
  localparam int MismatchLimit = 1000;

  typedef struct packed {
    logic [15:0] third;
    logic [15:0] second;
    logic [15:0] first;
    logic [7:0]  gender;
    logic [63:0] label;
    logic [63:0] key;
    cmd_t        cmd;
  } cmd_item_t;

  typedef struct packed {
    logic [15:0] mean;
    logic [17:0] total;
    logic [15:0] third;
    logic [15:0] second;
    logic [15:0] first;
    logic [7:0]  gender;
    logic [63:0] label;
    logic [63:0] key;
    status_t     status;
  } record_out_t;

  typedef struct {
    record_out_t rec;
    logic        last;
  } table_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [223:0] m_axis_tdata;
  logic         m_axis_tlast;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sorted_record_table u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // shadow copy of the table
  cmd_item_t     shadow [Depth];
  int            shadow_count = 0;
  table_result_t pending_results[$];
  int            mismatches = 0;
  int            results_seen = 0;
  int            inserts_done = 0, finds_done = 0, lists_done = 0, rejects_seen = 0;
  int            idle_cycles = 0;
  bit            hold_off = 1'b0;
  bit            stim_done = 1'b0;

  function automatic record_out_t record_of(cmd_item_t e);
    record_out_t r;
    logic [17:0] tot;
    tot = 18'(e.first) + 18'(e.second) + 18'(e.third);
    r.status = ST_OK;
    r.key = e.key;
    r.label = e.label;
    r.gender = e.gender;
    r.first = e.first;
    r.second = e.second;
    r.third = e.third;
    r.total = tot;
    r.mean = 16'((tot + 19'd1) / 19'd3);
    return r;
  endfunction

  function automatic record_out_t reject_of(status_t code);
    record_out_t r;
    r = '0;
    r.status = code;
    return r;
  endfunction

  task automatic push_result(record_out_t r, logic last);
    table_result_t t;
    t.rec = r;
    t.last = last;
    pending_results.push_back(t);
  endtask

  // updates the shadow table and queues what the block should report
  task automatic predict_table(cmd_item_t it);
    int pos;
    bit hit;
    hit = 1'b0;
    pos = 0;
    case (it.cmd)
      CMD_INSERT: begin
        for (int i = 0; i < shadow_count; i++)
          if (shadow[i].key == it.key) hit = 1'b1;
        if (hit) begin
          push_result(reject_of(ST_MISS), 1'b1);
          rejects_seen++;
        end else if (shadow_count >= Depth) begin
          push_result(reject_of(ST_FULL), 1'b1);
          rejects_seen++;
        end else begin
          while (pos < shadow_count && shadow[pos].key < it.key) pos++;
          for (int i = shadow_count; i > pos; i--) shadow[i] = shadow[i-1];
          shadow[pos] = it;
          shadow_count++;
          push_result(record_of(it), 1'b1);
          inserts_done++;
        end
      end
      CMD_LIST: begin
        for (int i = 0; i < shadow_count; i++)
          push_result(record_of(shadow[i]), i == shadow_count - 1);
        lists_done++;
      end
      CMD_FIND: begin
        for (int i = 0; i < shadow_count; i++)
          if (!hit && shadow[i].key == it.key) begin
            push_result(record_of(shadow[i]), 1'b1);
            hit = 1'b1;
          end
        if (!hit) push_result(reject_of(ST_MISS), 1'b1);
        finds_done++;
      end
      default: ;
    endcase
  endtask

  task automatic send_item(cmd_item_t it);
    s_axis_tdata <= {6'd0, it};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_table(it);
  endtask

  task automatic pause_sender();
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic cmd_item_t random_insert(logic [63:0] k);
    cmd_item_t it;
    it.cmd = CMD_INSERT;
    it.key = k;
    it.label = rand64();
    it.gender = 8'($urandom);
    it.first = 16'($urandom);
    it.second = 16'($urandom);
    it.third = 16'($urandom);
    return it;
  endfunction

  function automatic cmd_item_t make_cmd(cmd_t c, logic [63:0] k);
    cmd_item_t it;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[185:0];
    it.cmd = c;
    it.key = k;
    return it;
  endfunction

  function automatic logic [63:0] stored_key();
    if (shadow_count == 0) return rand64();
    return shadow[$urandom_range(0, shadow_count - 1)].key;
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // directed table: known keys and extremes
  cmd_item_t directed_rows[$];

  initial begin
    cmd_item_t it;
    int burst;
    directed_rows.push_back(make_cmd(CMD_LIST, 64'd0));
    directed_rows.push_back(make_cmd(CMD_FIND, 64'd5));
    it = random_insert(64'hFFFF_FFFF_FFFF_FFFF);
    it.first = 16'hFFFF; it.second = 16'hFFFF; it.third = 16'hFFFF;
    it.label = '1; it.gender = 8'hFF;
    directed_rows.push_back(it);
    it = random_insert(64'd0);
    it.first = 16'd0; it.second = 16'd0; it.third = 16'd0; it.label = '0; it.gender = 8'd0;
    directed_rows.push_back(it);
    directed_rows.push_back(random_insert(64'h4142_4300_0000_0000));
    directed_rows.push_back(random_insert(64'h4142_4300_0000_0000));
    directed_rows.push_back(random_insert(64'h3000_0000_0000_0000));
    it = random_insert(64'h5A00_0000_0000_0000);
    it.first = 16'd1; it.second = 16'd0; it.third = 16'd0;
    directed_rows.push_back(it);
    it = random_insert(64'h5A5A_0000_0000_0000);
    it.first = 16'd2; it.second = 16'd0; it.third = 16'd0;
    directed_rows.push_back(it);
    directed_rows.push_back(make_cmd(CMD_FIND, 64'h3000_0000_0000_0000));
    directed_rows.push_back(make_cmd(CMD_FIND, 64'hFFFF_FFFF_FFFF_FFFF));
    directed_rows.push_back(make_cmd(CMD_FIND, 64'h1234));
    directed_rows.push_back(make_cmd(CMD_NONE, 64'd0));
    directed_rows.push_back(make_cmd(CMD_LIST, 64'd0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i]);
      pause_sender();
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // random part: fill toward capacity, hit the full table, then churn finds/lists
    burst = 0;
    for (int n = 0; n < RandomItems; n++) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (n >= 150 && n < 220) it = random_insert(rand64());
      else if (pick < 45) it = random_insert($urandom_range(0, 3) == 0 ? stored_key() : rand64());
      else if (pick < 75) it = make_cmd(CMD_FIND, $urandom_range(0, 1) ? stored_key() : rand64());
      else if (pick < 93) it = make_cmd(CMD_LIST, rand64());
      else it = make_cmd(CMD_NONE, rand64());
      send_item(it);
      if (burst == 0) begin
        burst = $urandom_range(1, 10);
        pause_sender();
      end else begin
        burst--;
      end
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall pattern, with one long hold-off during the random part
  initial begin
    int phase;
    phase = 0;
    while (rst) @(posedge clk);
    while (1) begin
      @(posedge clk);
      phase++;
      if (phase == 2000) begin
        hold_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      if ((phase / 300) % 3 == 0) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      record_out_t got;
      table_result_t want;
      got = record_out_t'(m_axis_tdata[219:0]);
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got !== want.rec || m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: exp %h last %b, got %h last %b",
                     results_seen, want.rec, want.last, got, m_axis_tlast);
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    while (!(stim_done && pending_results.size() == 0)) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit || mismatches >= MismatchLimit) begin
        $display("stopped: %0d results outstanding, %0d mismatches",
                 pending_results.size(), mismatches);
        $display("== FAIL ==");
        $finish;
      end
    end
    repeat (300) @(posedge clk);
    $display("covered %0d inserts, %0d rejects, %0d finds, %0d lists, %0d results",
             inserts_done, rejects_seen, finds_done, lists_done, results_seen);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

FILE: files.f
design/srt_pkg.sv
design/srt_ram.sv
design/srt_ctrl.sv
design/srt_dp.sv
design/sorted_record_table.sv
design/srt_check.sv
tb/tb_top.sv
